/* hdl/gct_pkg.sv */
// ============================================================================
// gct_pkg
// Shared constants, types and command/status structs for the centroid tracker.
// ============================================================================
`default_nettype none

package gct_pkg;

    // table geometry
    localparam int TRACKS   = 16;
    localparam int IDX_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CNT_W    = $clog2(TRACKS + 1);
    localparam int BANKS    = 2;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int RAM_DEPTH = BANKS * (1 << IDX_W);

    // field widths
    localparam int POS_W    = 16;
    localparam int ID_W     = 16;
    localparam int GATE_W   = 16;
    localparam int COUNT_W  = 5;

    // stream payload widths, packed and padded to whole bytes
    localparam int IN_DATA_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ID_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(800);
    localparam logic [ID_W-1:0]   ID_FIRST   = ID_W'(1);

    typedef enum logic {
        OP_DETECT = 1'b0,
        OP_EOF    = 1'b1
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic             load_item;   // latch position, clear search state
        logic             rd_en;       // issue table read
        logic             rd_cur;      // 1: current bank, 0: building bank
        logic [IDX_W-1:0] rd_idx;
        logic             resolve;     // fix id, allocate if unmatched
        logic             commit_det;  // write entry, load result
        logic             commit_eof;  // swap banks, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] cur_count;
        logic [CNT_W-1:0] bld_count;
        logic             out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/gct_ram.sv */
// ============================================================================
// gct_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module gct_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/gct_ctrl.sv */
// ============================================================================
// gct_ctrl
// Sequencer: scans current table, resolves id, scans building table, commits; end of frame skips the scans.
// ============================================================================
`default_nettype none

module gct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire gct_pkg::t_op  i_in_op,
    output logic               o_in_ready,
    output gct_pkg::t_cmd      o_cmd,
    input  wire gct_pkg::t_sts i_sts
);
    import gct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_CUR,
        S_RESOLVE,
        S_SCAN_BLD,
        S_COMMIT,
        S_EOF
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= (i_in_op == OP_EOF) ? S_EOF : S_SCAN_CUR;
                    end
                end
                S_SCAN_CUR: begin
                    if (r_idx < i_sts.cur_count) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_state <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    r_idx   <= '0;
                    r_state <= S_SCAN_BLD;
                end
                S_SCAN_BLD: begin
                    if (r_idx < i_sts.bld_count) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT, S_EOF: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_item  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en      = ((r_state == S_SCAN_CUR) && (r_idx < i_sts.cur_count)) ||
                           ((r_state == S_SCAN_BLD) && (r_idx < i_sts.bld_count));
        o_cmd.rd_cur     = (r_state == S_SCAN_CUR);
        o_cmd.rd_idx     = r_idx[IDX_W-1:0];
        o_cmd.resolve    = (r_state == S_RESOLVE);
        o_cmd.commit_det = (r_state == S_COMMIT) && i_sts.out_free;
        o_cmd.commit_eof = (r_state == S_EOF) && i_sts.out_free;
    end

`ifndef SYNTHESIS
    a_det_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_item && i_in_op == OP_DETECT) |=> (r_state == S_SCAN_CUR && r_idx == '0))
        else $error("detection did not start current-table scan");
    a_resolve_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE) |-> ($past(r_state) == S_SCAN_CUR))
        else $error("resolve entered without current-table scan");
`endif

endmodule

`default_nettype wire

/* hdl/gct_dp.sv */
// ============================================================================
// gct_dp
// Datapath: ping-pong track tables, gate compare, id allocation, result reg.
// ============================================================================
`default_nettype none

module gct_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gct_pkg::t_cmd                  i_cmd,
    output gct_pkg::t_sts                       o_sts,
    input  wire logic [gct_pkg::POS_W-1:0]      i_pos_x,
    input  wire logic [gct_pkg::POS_W-1:0]      i_pos_y,
    input  wire logic                           i_cfg_valid,
    input  wire logic [gct_pkg::GATE_W-1:0]     i_cfg_data,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic      [gct_pkg::ID_W-1:0]       o_track_id,
    output logic                                o_is_new,
    output logic                                o_overflow,
    output logic      [gct_pkg::COUNT_W-1:0]    o_track_count
);
    import gct_pkg::*;

    logic [GATE_W-1:0] r_gate;
    logic [POS_W-1:0]  r_px, r_py;
    logic              r_bank;       // bank holding the current table
    logic [CNT_W-1:0]  r_cur_count, r_bld_count;
    logic [ID_W-1:0]   r_id_ctr;
    logic              r_found, r_fresh, r_hit;
    logic [ID_W-1:0]   r_id;
    logic [IDX_W-1:0]  r_slot;
    logic              r_rd_cur_d, r_rd_bld_d;
    logic [IDX_W-1:0]  r_rd_idx_d;
    logic              r_out_vld, r_out_new, r_out_ovf;
    logic [ID_W-1:0]   r_out_id;
    logic [COUNT_W-1:0] r_out_cnt;

    t_entry            rd_entry, wr_entry;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [POS_W-1:0]  dx, dy;
    logic              in_gate, full;
    logic [ID_W-1:0]   n_id_ctr;
    logic [CNT_W-1:0]  n_bld_count;

    // gate test on the entry just read
    assign dx      = (r_px >= rd_entry.x) ? (r_px - rd_entry.x) : (rd_entry.x - r_px);
    assign dy      = (r_py >= rd_entry.y) ? (r_py - rd_entry.y) : (rd_entry.y - r_py);
    assign in_gate = (dx < r_gate) && (dy < r_gate);

    assign n_id_ctr = (r_id_ctr == {ID_W{1'b1}}) ? ID_FIRST : (r_id_ctr + ID_W'(1));

    // building table fills in order, so the first free slot is the count
    assign full        = (r_bld_count == CNT_W'(TRACKS));
    assign wr_idx      = r_hit ? r_slot : r_bld_count[IDX_W-1:0];
    assign wr_en       = i_cmd.commit_det && (r_hit || !full);
    assign n_bld_count = r_bld_count + CNT_W'(!r_hit && !full);

    assign rd_addr  = {(i_cmd.rd_cur ? r_bank : ~r_bank), i_cmd.rd_idx};
    assign wr_addr  = {~r_bank, wr_idx};
    assign wr_entry = '{id: r_id, x: r_px, y: r_py};

    gct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= GATE_RESET;
            r_bank      <= 1'b0;
            r_cur_count <= '0;
            r_bld_count <= '0;
            r_id_ctr    <= ID_FIRST;
            r_found     <= 1'b0;
            r_fresh     <= 1'b0;
            r_hit       <= 1'b0;
            r_rd_cur_d  <= 1'b0;
            r_rd_bld_d  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gate <= i_cfg_data;
            end
            r_rd_cur_d <= i_cmd.rd_en && i_cmd.rd_cur;
            r_rd_bld_d <= i_cmd.rd_en && !i_cmd.rd_cur;

            if (i_cmd.load_item) begin
                r_found <= 1'b0;
                r_fresh <= 1'b0;
                r_hit   <= 1'b0;
            end
            // lowest matching id wins
            if (r_rd_cur_d && in_gate && (!r_found || rd_entry.id < r_id)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.resolve && !r_found) begin
                r_fresh  <= 1'b1;
                r_id_ctr <= n_id_ctr;
            end
            if (r_rd_bld_d && !r_hit && rd_entry.id == r_id) begin
                r_hit <= 1'b1;
            end

            if (i_cmd.commit_det) begin
                r_bld_count <= n_bld_count;
            end else if (i_cmd.commit_eof) begin
                r_bank      <= ~r_bank;
                r_cur_count <= r_bld_count;
                r_bld_count <= '0;
            end

            if (i_cmd.commit_det || i_cmd.commit_eof) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (r_rd_cur_d && in_gate && (!r_found || rd_entry.id < r_id)) begin
            r_id <= rd_entry.id;
        end else if (i_cmd.resolve && !r_found) begin
            r_id <= r_id_ctr;
        end
        if (r_rd_bld_d && !r_hit && rd_entry.id == r_id) begin
            r_slot <= r_rd_idx_d;
        end
        r_rd_idx_d <= i_cmd.rd_idx;

        if (i_cmd.commit_det) begin
            r_out_id  <= r_id;
            r_out_new <= r_fresh;
            r_out_ovf <= !r_hit && full;
            r_out_cnt <= COUNT_W'(n_bld_count);
        end else if (i_cmd.commit_eof) begin
            r_out_id  <= '0;
            r_out_new <= 1'b0;
            r_out_ovf <= 1'b0;
            r_out_cnt <= COUNT_W'(r_bld_count);
        end
    end

    assign o_sts.cur_count = r_cur_count;
    assign o_sts.bld_count = r_bld_count;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_track_id    = r_out_id;
    assign o_is_new      = r_out_new;
    assign o_overflow    = r_out_ovf;
    assign o_track_count = r_out_cnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_count <= CNT_W'(TRACKS)) && (r_bld_count <= CNT_W'(TRACKS)))
        else $error("track count beyond table size");
    a_ctr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_ctr != '0)
        else $error("id counter reached zero");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ovf) |-> (r_out_cnt == COUNT_W'(TRACKS)))
        else $error("overflow reported with room in building table");
`endif

endmodule

`default_nettype wire

/* hdl/gated_centroid_tracker.sv */
// ============================================================================
// gated_centroid_tracker
// Frame-by-frame association of object centroids to track ids.
// ============================================================================
// Usage:
//   s_axis_*  one transfer per item. tuser = operation (0 detection, 1 end of
//             frame); tdata = pos_x[15:0], pos_y[31:16] (12.4 pixels).
//   m_axis_*  one transfer per item. tdata = track_id[15:0],
//             track_count[20:16]; tuser = is_new[0], table_overflow[1].
//   i_cfg_*   writes gate_distance; always ready, take it while idle.
// Timing:
//   A detection scans the current table (C entries), then the building table
//   (B entries), one entry per cycle through the single table RAM read port.
//   The result register loads at commit, and the next input is taken only once
//   the controller is back in idle, so detections are processed one at a time.
//   End of frame swaps the two RAM banks; its result carries the frame's track count.
// Backpressure: the result sits in an output register; the block still takes
//   and scans the next item, and holds it at commit until the register frees.
// Reset: gate 800, both tables empty, next fresh id 1. RAM is not cleared;
//   fill counts keep unwritten entries from being read.
// ============================================================================
`default_nettype none

module gated_centroid_tracker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [gct_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // pos_x, pos_y
    input  wire logic                               s_axis_tuser,  // operation
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [gct_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // track_id, track_count
    output logic      [gct_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // is_new, table_overflow
    // gate register write
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gct_pkg::GATE_W-1:0]         i_cfg_data
);
    import gct_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    t_op                in_op;
    logic [ID_W-1:0]    track_id;
    logic [COUNT_W-1:0] track_count;
    logic               is_new, overflow;

    assign in_op = t_op'(s_axis_tuser);

    // config register has no side effects to wait on
    assign o_cfg_ready = 1'b1;

    gct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (in_op),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    gct_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pos_x       (s_axis_tdata[POS_W-1:0]),
        .i_pos_y       (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_track_id    (track_id),
        .o_is_new      (is_new),
        .o_overflow    (overflow),
        .o_track_count (track_count)
    );

    assign m_axis_tdata = OUT_DATA_W'({track_count, track_id});
    assign m_axis_tuser = {overflow, is_new};

endmodule

`default_nettype wire
